### rtl/dutc_pkg.sv
// dutc_pkg: shared types and constants for the dos/unix timestamp converter
// holds the item and result beat structs, calendar constants and reciprocals
// no dependencies
`default_nettype none

package dutc_pkg;

    typedef struct packed {
        logic               mode;
        logic [15:0]        dos_time;
        logic [15:0]        dos_date;
        logic signed [31:0] unix_seconds;
    } item_t;

    typedef struct packed {
        logic signed [31:0] unix_seconds_out;
        logic [15:0]        dos_time_out;
        logic [15:0]        dos_date_out;
    } result_t;

    // conversion direction carried in item.mode
    localparam logic        MODE_DOS_TO_UNIX   = 1'b0;
    localparam logic        MODE_UNIX_TO_DOS   = 1'b1;

    localparam logic [30:0] EPOCH_1980_SECS    = 31'd315532800;
    localparam logic [16:0] SECS_PER_DAY       = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR      = 12'd3600;
    localparam logic [5:0]  SECS_PER_MINUTE    = 6'd60;
    localparam logic [8:0]  DAYS_PER_YEAR      = 9'd365;
    localparam logic [11:0] DAYS_1970_TO_1980  = 12'd3652;
    localparam logic [8:0]  LEAP_DAY_OF_YEAR   = 9'd59;
    localparam logic [3:0]  MONTHS_PER_YEAR    = 4'd12;

    // floor(2^s / d) reciprocals, quotient comes out exact or one low
    localparam logic [15:0] RECIP_DAY          = 16'd49710;   // 2^32 / 86400
    localparam logic [15:0] RECIP_YEAR         = 16'd45964;   // 2^24 / 365
    localparam logic [12:0] RECIP_HOUR         = 13'd4660;    // 2^24 / 3600
    localparam logic [14:0] RECIP_MINUTE       = 15'd17476;   // 2^20 / 60

    // days before the first of each month, non-leap year
    function automatic logic [8:0] month_start(input logic [3:0] idx);
        logic [8:0] days;
        case (idx)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd31;
            4'd2:    days = 9'd59;
            4'd3:    days = 9'd90;
            4'd4:    days = 9'd120;
            4'd5:    days = 9'd151;
            4'd6:    days = 9'd181;
            4'd7:    days = 9'd212;
            4'd8:    days = 9'd243;
            4'd9:    days = 9'd273;
            4'd10:   days = 9'd304;
            4'd11:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

`default_nettype wire

### rtl/dos_unix_timestamp_convert_unit.sv
// dos_unix_timestamp_convert_unit: fat/dos packed date-time <-> unix seconds
// nine-stage pipeline, uses types and constants from dutc_pkg
//
// usage:
//   item channel (item_valid / item_stall / item) carries one conversion
//   request per beat; item.mode 0 turns dos_time/dos_date into unix seconds,
//   mode 1 turns unix_seconds into dos_time/dos_date. the unused result
//   fields read zero.
//   result channel (result_valid / result_stall / result) returns exactly one
//   beat per accepted item, in order.
//   cfg channel (cfg_valid / cfg_ready / cfg_data) writes the zone offset in
//   minutes west of utc; cfg_ready is always high, write only while idle.
//   path: each item passes through the nine register stages; stage 9 holds the result.
//   throughput: one item per cycle while result_stall is low; each stage
//   (reciprocal multiplies for day, hour, minute and year, then month lookup)
//   takes a new beat every cycle unless it is full and held.
//   stall: each stage holds when it is full and the one after it holds, so
//   bubbles close up and item_stall rises only when every stage is full and
//   result_stall is high.
//   reset: all stages empty, zone offset zero.
`default_nettype none

module dos_unix_timestamp_convert_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire dutc_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output dutc_pkg::result_t      result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic signed [10:0] cfg_data
);
    import dutc_pkg::*;

    localparam int NUM_STAGES = 9;

    // control
    logic [NUM_STAGES:1] v_reg;
    logic [NUM_STAGES:1] en;
    logic signed [17:0]  zone_secs_reg;
    logic signed [17:0]  zone_secs_next;
    logic [31:0]         zone_ext;

    // stage 1
    logic [31:0] w_diff;
    logic [3:0]  mon_idx;
    logic [6:0]  dyear;
    logic        s1_mode_reg;
    logic [30:0] s1_w_reg, s1_w_next;
    logic [16:0] s1_days_reg, s1_days_next;
    logic [16:0] s1_tsecs_reg, s1_tsecs_next;

    // stage 2
    logic [33:0] day_prod;
    logic [46:0] q_prod;
    logic        s2_mode_reg;
    logic [31:0] s2_prod_reg, s2_prod_next;
    logic [16:0] s2_tsecs_reg;
    logic [14:0] s2_q0_reg, s2_q0_next;
    logic [30:0] s2_w_reg;

    // stage 3
    logic        s3_mode_reg;
    logic [31:0] s3_sum_reg, s3_sum_next;
    logic [31:0] s3_qd_reg, s3_qd_next;
    logic [14:0] s3_q0_reg;
    logic [30:0] s3_w_reg;

    // stage 4
    logic [31:0] r_diff;
    logic [17:0] r_a;
    logic        s4_mode_reg;
    logic [31:0] s4_sum_reg;
    logic [16:0] s4_r_reg, s4_r_next;
    logic [14:0] s4_q_reg, s4_q_next;

    // stage 5
    logic [30:0] y_prod;
    logic [29:0] h_prod;
    logic        s5_mode_reg;
    logic [31:0] s5_sum_reg;
    logic [14:0] s5_day_reg, s5_day_next;
    logic [6:0]  s5_y0_reg, s5_y0_next;
    logic [16:0] s5_r_reg;
    logic [5:0]  s5_h0_reg, s5_h0_next;

    // stage 6
    logic [14:0] y_rem;
    logic [16:0] r2_a;
    logic        s6_mode_reg;
    logic [31:0] s6_sum_reg;
    logic [14:0] s6_day_reg;
    logic [6:0]  s6_y1_reg, s6_y1_next;
    logic [4:0]  s6_h_reg, s6_h_next;
    logic [11:0] s6_r2_reg, s6_r2_next;

    // stage 7
    logic [6:0]  y_m1;
    logic [7:0]  ya_p3, yb_p3;
    logic [14:0] base_a, base_b;
    logic [26:0] m_prod;
    logic        s7_mode_reg;
    logic [31:0] s7_sum_reg;
    logic [6:0]  s7_y_reg, s7_y_next;
    logic [8:0]  s7_doy_reg, s7_doy_next;
    logic [4:0]  s7_h_reg;
    logic [11:0] s7_r2_reg;
    logic [5:0]  s7_m0_reg, s7_m0_next;

    // stage 8
    logic [11:0] r3_a;
    logic        leap;
    logic        s8_mode_reg;
    logic [31:0] s8_sum_reg;
    logic [6:0]  s8_y_reg;
    logic [8:0]  s8_nl_reg, s8_nl_next;
    logic [3:0]  s8_month_reg, s8_month_next;
    logic [4:0]  s8_h_reg;
    logic [5:0]  s8_m_reg, s8_m_next;
    logic [5:0]  s8_r3_reg, s8_r3_next;

    // stage 9
    result_t     result_reg, result_next;

    // ---------------------------------------------------------------
    // handshake: a stage loads when empty or when the next one loads
    always_comb
    begin
        en[NUM_STAGES] = !v_reg[NUM_STAGES] || !result_stall;
        for (int k = NUM_STAGES - 1; k >= 1; k--)
        begin
            en[k] = !v_reg[k] || en[k + 1];
        end
    end

    assign item_stall   = !en[1];
    assign result_valid = v_reg[NUM_STAGES];
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                v_reg[1] <= item_valid;
            end
            for (int k = 2; k <= NUM_STAGES; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k - 1];
                end
            end
        end
    end

    // zone offset kept in seconds
    assign zone_secs_next = 18'(signed'(cfg_data)) * 18'sd60;
    assign zone_ext       = {{14{zone_secs_reg[17]}}, zone_secs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_secs_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            zone_secs_reg <= zone_secs_next;
        end
    end

    // ---------------------------------------------------------------
    // stage 1: day count and time of day for dos input, clamp for unix input
    always_comb
    begin
        w_diff = $unsigned(item.unix_seconds) - zone_ext;
        if (w_diff[31] || (w_diff[30:0] < EPOCH_1980_SECS))
        begin
            s1_w_next = EPOCH_1980_SECS;
        end
        else
        begin
            s1_w_next = w_diff[30:0];
        end

        mon_idx = item.dos_date[8:5] - 4'd1;
        dyear   = item.dos_date[15:9];
        s1_days_next = 17'(item.dos_date[4:0]) + 17'(month_start(mon_idx))
                     + 17'(dyear[6:2]) + 17'(dyear) * 17'(DAYS_PER_YEAR)
                     + 17'(DAYS_1970_TO_1980);
        // leap year, before the leap day
        if ((dyear[1:0] == 2'd0) && (mon_idx < 4'd2))
        begin
            s1_days_next = s1_days_next - 17'd1;
        end

        s1_tsecs_next = 17'(item.dos_time[4:0]) * 17'd2
                      + 17'(item.dos_time[10:5]) * 17'(SECS_PER_MINUTE)
                      + 17'(item.dos_time[15:11]) * 17'(SECS_PER_HOUR);
    end

    // stage 2
    always_comb
    begin
        day_prod     = 34'(s1_days_reg) * 34'(SECS_PER_DAY);
        s2_prod_next = day_prod[31:0];
        q_prod       = 47'(s1_w_reg) * 47'(RECIP_DAY);
        s2_q0_next   = q_prod[46:32];
    end

    // stage 3
    always_comb
    begin
        s3_sum_next = s2_prod_reg + 32'(s2_tsecs_reg) + zone_ext;
        s3_qd_next  = 32'(s2_q0_reg) * 32'(SECS_PER_DAY);
    end

    // stage 4: seconds of day, fix day quotient
    always_comb
    begin
        r_diff = 32'(s3_w_reg) - s3_qd_reg;
        r_a    = r_diff[17:0];
        if (r_a >= 18'(SECS_PER_DAY))
        begin
            s4_r_next = 17'(r_a - 18'(SECS_PER_DAY));
            s4_q_next = s3_q0_reg + 15'd1;
        end
        else
        begin
            s4_r_next = r_a[16:0];
            s4_q_next = s3_q0_reg;
        end
    end

    // stage 5: estimate year and hour
    always_comb
    begin
        s5_day_next = s4_q_reg - 15'(DAYS_1970_TO_1980);
        y_prod      = 31'(s5_day_next) * 31'(RECIP_YEAR);
        s5_y0_next  = y_prod[30:24];
        h_prod      = 30'(s4_r_reg) * 30'(RECIP_HOUR);
        s5_h0_next  = h_prod[29:24];
    end

    // stage 6: fix year and hour estimates
    always_comb
    begin
        y_rem = s5_day_reg - 15'(s5_y0_reg) * 15'(DAYS_PER_YEAR);
        if (y_rem >= 15'(DAYS_PER_YEAR))
        begin
            s6_y1_next = s5_y0_reg + 7'd1;
        end
        else
        begin
            s6_y1_next = s5_y0_reg;
        end

        r2_a = s5_r_reg - 17'(s5_h0_reg) * 17'(SECS_PER_HOUR);
        if (r2_a >= 17'(SECS_PER_HOUR))
        begin
            s6_h_next  = 5'(s5_h0_reg + 6'd1);
            s6_r2_next = 12'(r2_a - 17'(SECS_PER_HOUR));
        end
        else
        begin
            s6_h_next  = s5_h0_reg[4:0];
            s6_r2_next = r2_a[11:0];
        end
    end

    // stage 7: step back a year when leap days push the year start past the day, estimate minute
    always_comb
    begin
        y_m1   = s6_y1_reg - 7'd1;
        ya_p3  = 8'(s6_y1_reg) + 8'd3;
        yb_p3  = 8'(y_m1) + 8'd3;
        base_a = 15'(ya_p3[7:2]) + 15'(s6_y1_reg) * 15'(DAYS_PER_YEAR);
        base_b = 15'(yb_p3[7:2]) + 15'(y_m1) * 15'(DAYS_PER_YEAR);
        if (base_a > s6_day_reg)
        begin
            s7_y_next   = y_m1;
            s7_doy_next = 9'(s6_day_reg - base_b);
        end
        else
        begin
            s7_y_next   = s6_y1_reg;
            s7_doy_next = 9'(s6_day_reg - base_a);
        end

        m_prod     = 27'(s6_r2_reg) * 27'(RECIP_MINUTE);
        s7_m0_next = m_prod[25:20];
    end

    // stage 8: month search, minute fix
    always_comb
    begin
        leap = (s7_y_reg[1:0] == 2'd0);
        if ((s7_doy_reg == LEAP_DAY_OF_YEAR) && leap)
        begin
            s8_nl_next    = s7_doy_reg;
            s8_month_next = 4'd2;
        end
        else
        begin
            if (!leap || (s7_doy_reg <= LEAP_DAY_OF_YEAR))
            begin
                s8_nl_next = s7_doy_reg;
            end
            else
            begin
                s8_nl_next = s7_doy_reg - 9'd1;
            end
            s8_month_next = '0;
            for (int k = 0; k < 12; k++)
            begin
                if (month_start(4'(k)) <= s8_nl_next)
                begin
                    s8_month_next = s8_month_next + 4'd1;
                end
            end
        end

        r3_a = s7_r2_reg - 12'(s7_m0_reg) * 12'(SECS_PER_MINUTE);
        if (r3_a >= 12'(SECS_PER_MINUTE))
        begin
            s8_m_next  = s7_m0_reg + 6'd1;
            s8_r3_next = 6'(r3_a - 12'(SECS_PER_MINUTE));
        end
        else
        begin
            s8_m_next  = s7_m0_reg;
            s8_r3_next = r3_a[5:0];
        end
    end

    // stage 9: pack result
    always_comb
    begin
        result_next = '0;
        if (s8_mode_reg == MODE_UNIX_TO_DOS)
        begin
            result_next.dos_time_out = {s8_h_reg, s8_m_reg, s8_r3_reg[5:1]};
            if (s8_month_reg > MONTHS_PER_YEAR)
            begin
                result_next.dos_date_out = '0;
            end
            else
            begin
                result_next.dos_date_out = 16'(s8_nl_reg)
                    - 16'(month_start(s8_month_reg - 4'd1)) + 16'd1
                    + {7'd0, s8_month_reg, 5'd0} + {s8_y_reg, 9'd0};
            end
        end
        else
        begin
            result_next.unix_seconds_out = signed'(s8_sum_reg);
        end
    end

    // ---------------------------------------------------------------
    // payload registers
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_mode_reg  <= item.mode;
            s1_w_reg     <= s1_w_next;
            s1_days_reg  <= s1_days_next;
            s1_tsecs_reg <= s1_tsecs_next;
        end
        if (en[2])
        begin
            s2_mode_reg  <= s1_mode_reg;
            s2_prod_reg  <= s2_prod_next;
            s2_tsecs_reg <= s1_tsecs_reg;
            s2_q0_reg    <= s2_q0_next;
            s2_w_reg     <= s1_w_reg;
        end
        if (en[3])
        begin
            s3_mode_reg <= s2_mode_reg;
            s3_sum_reg  <= s3_sum_next;
            s3_qd_reg   <= s3_qd_next;
            s3_q0_reg   <= s2_q0_reg;
            s3_w_reg    <= s2_w_reg;
        end
        if (en[4])
        begin
            s4_mode_reg <= s3_mode_reg;
            s4_sum_reg  <= s3_sum_reg;
            s4_r_reg    <= s4_r_next;
            s4_q_reg    <= s4_q_next;
        end
        if (en[5])
        begin
            s5_mode_reg <= s4_mode_reg;
            s5_sum_reg  <= s4_sum_reg;
            s5_day_reg  <= s5_day_next;
            s5_y0_reg   <= s5_y0_next;
            s5_r_reg    <= s4_r_reg;
            s5_h0_reg   <= s5_h0_next;
        end
        if (en[6])
        begin
            s6_mode_reg <= s5_mode_reg;
            s6_sum_reg  <= s5_sum_reg;
            s6_day_reg  <= s5_day_reg;
            s6_y1_reg   <= s6_y1_next;
            s6_h_reg    <= s6_h_next;
            s6_r2_reg   <= s6_r2_next;
        end
        if (en[7])
        begin
            s7_mode_reg <= s6_mode_reg;
            s7_sum_reg  <= s6_sum_reg;
            s7_y_reg    <= s7_y_next;
            s7_doy_reg  <= s7_doy_next;
            s7_h_reg    <= s6_h_reg;
            s7_r2_reg   <= s6_r2_reg;
            s7_m0_reg   <= s7_m0_next;
        end
        if (en[8])
        begin
            s8_mode_reg  <= s7_mode_reg;
            s8_sum_reg   <= s7_sum_reg;
            s8_y_reg     <= s7_y_reg;
            s8_nl_reg    <= s8_nl_next;
            s8_month_reg <= s8_month_next;
            s8_h_reg     <= s7_h_reg;
            s8_m_reg     <= s8_m_next;
            s8_r3_reg    <= s8_r3_next;
        end
        if (en[9])
        begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire
